@@ rtl/core/ppu_pkg.sv @@
package ppu_pkg;

    // Pixel mode codes held in the pixel_mode register.
    localparam logic [1:0] MODE_RAW10  = 2'd0;
    localparam logic [1:0] MODE_RAW12  = 2'd1;
    localparam logic [1:0] MODE_SWAP16 = 2'd2;
    localparam logic [1:0] MODE_RESET  = MODE_RAW12;

    // Register indexes on the configuration port.
    localparam logic REG_PIXEL_MODE = 1'b0;

    // Default depth of the group queue between front and back.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Number of pixels a group can carry at most.
    localparam int MAX_PIXELS = 4;

    // One beat of the byte channel.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } byte_beat_t;

    // One beat of the pixel channel.
    typedef struct packed {
        logic [15:0] pixel_value;
        logic        last_of_group;
    } pixel_beat_t;

    // A completed group, ready to be emitted pixel by pixel.
    typedef struct packed {
        logic [MAX_PIXELS-1:0][15:0] pixels;
        logic [1:0]                  last_idx;
    } group_t;

    // Status of the group queue as seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

@@ rtl/core/ppu_front.sv @@
module ppu_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          pixel_mode,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  ppu_pkg::byte_beat_t byte_data,
    input  logic                queue_full,
    output logic                push,
    output ppu_pkg::group_t     push_group
);

    logic [2:0] pos_reg;
    logic [2:0] pos_next;
    logic [7:0] held_reg [4];

    logic [2:0] pos_eff;
    logic [2:0] last_index;
    logic       mode_ok;
    logic       take;
    logic       is_last;

    // The front only holds off when the queue has no room for a group.
    assign byte_stall = queue_full;
    assign take       = byte_valid && !byte_stall;

    // Frame start rewinds the group position before the byte is taken.
    assign pos_eff = byte_data.frame_start ? 3'd0 : pos_reg;

    // Index of the final byte of a group in the current mode.
    always_comb
    begin
        mode_ok    = 1'b1;
        last_index = 3'd0;
        unique case (pixel_mode)
            ppu_pkg::MODE_RAW10:  last_index = 3'd4;
            ppu_pkg::MODE_RAW12:  last_index = 3'd2;
            ppu_pkg::MODE_SWAP16: last_index = 3'd1;
            default:              mode_ok    = 1'b0;
        endcase
    end

    // A position at or beyond the last index closes the group, even after a mode change.
    assign is_last = mode_ok && (pos_eff >= last_index);
    assign push    = take && is_last;

    always_comb
    begin
        pos_next = pos_reg;
        if (take)
        begin
            if (!mode_ok)
            begin
                pos_next = pos_eff;
            end
            else if (is_last)
            begin
                pos_next = 3'd0;
            end
            else
            begin
                pos_next = pos_eff + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 3'd0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // High bytes of the open group; no reset, as each is written before it is read.
    always_ff @(posedge clk)
    begin
        if (take && mode_ok && !is_last)
        begin
            held_reg[pos_eff[1:0]] <= byte_data.data_byte;
        end
    end

    // Assemble the pixels of the group from the held bytes and the closing byte.
    always_comb
    begin
        push_group = '0;
        unique case (pixel_mode)
            ppu_pkg::MODE_RAW10:
            begin
                push_group.pixels[0] = {held_reg[0], byte_data.data_byte[1:0], 6'b0};
                push_group.pixels[1] = {held_reg[1], byte_data.data_byte[3:2], 6'b0};
                push_group.pixels[2] = {held_reg[2], byte_data.data_byte[5:4], 6'b0};
                push_group.pixels[3] = {held_reg[3], byte_data.data_byte[7:6], 6'b0};
                push_group.last_idx  = 2'd3;
            end
            ppu_pkg::MODE_RAW12:
            begin
                push_group.pixels[0] = {held_reg[0], byte_data.data_byte[3:0], 4'b0};
                push_group.pixels[1] = {held_reg[1], byte_data.data_byte[7:4], 4'b0};
                push_group.last_idx  = 2'd1;
            end
            ppu_pkg::MODE_SWAP16:
            begin
                push_group.pixels[0] = {held_reg[0], byte_data.data_byte};
                push_group.last_idx  = 2'd0;
            end
            default:
            begin
                push_group = '0;
            end
        endcase
    end

endmodule

@@ rtl/core/ppu_queue.sv @@
module ppu_queue #(
    parameter int DEPTH = ppu_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ppu_pkg::group_t       push_group,
    input  logic                  pop,
    output ppu_pkg::group_t       head_group,
    output ppu_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ppu_pkg::group_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_group   = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Group storage carries payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_group;
        end
    end

endmodule

@@ rtl/core/ppu_back.sv @@
module ppu_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ppu_pkg::group_t        head_group,
    input  ppu_pkg::queue_status_t status,
    output logic                   pop,
    output logic                   pixel_valid,
    input  logic                   pixel_stall,
    output ppu_pkg::pixel_beat_t   pixel_data
);

    logic [1:0]           idx_reg;
    logic [1:0]           idx_next;
    logic                 valid_reg;
    logic                 valid_next;
    ppu_pkg::pixel_beat_t data_reg;
    logic                 load;
    logic                 at_last;

    // The output register takes a new pixel whenever it is empty or being drained.
    assign load    = !status.empty && (!valid_reg || !pixel_stall);
    assign at_last = (idx_reg == head_group.last_idx);
    assign pop     = load && at_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && pixel_stall;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = at_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Pixel payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg.pixel_value   <= head_group.pixels[idx_reg];
            data_reg.last_of_group <= at_last;
        end
    end

    assign pixel_valid = valid_reg;
    assign pixel_data  = data_reg;

endmodule

@@ rtl/core/packed_pixel_unpacker.sv @@
// Channel   Direction  Beat           Handshake
// byte      in         byte_beat_t    byte_valid / byte_stall
// pixel     out        pixel_beat_t   pixel_valid / pixel_stall
// config    in/out     APB, 32 bits   psel / penable / pready
//
// One byte is taken per clock unless byte_stall holds it; a closing byte queues a group
// of one, two or four pixels. The back emits one pixel per clock, unless pixel_stall holds
// it, from the group queue through an output register.
// byte_stall rises only while the group queue (QUEUE_DEPTH groups) is full.
// Reset clears the group position, the queue and the output; pixel_mode returns to 12-bit.
module packed_pixel_unpacker #(
    parameter int QUEUE_DEPTH = ppu_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  ppu_pkg::byte_beat_t  byte_data,
    output logic                 pixel_valid,
    input  logic                 pixel_stall,
    output ppu_pkg::pixel_beat_t pixel_data
);

    logic [1:0]             mode_reg;
    logic [1:0]             mode_next;
    logic                   cfg_write;
    logic                   push;
    logic                   pop;
    ppu_pkg::group_t        push_group;
    ppu_pkg::group_t        head_group;
    ppu_pkg::queue_status_t status;

    // Configuration register access.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == ppu_pkg::REG_PIXEL_MODE);
    assign mode_next = cfg_write ? pwdata[1:0] : mode_reg;
    assign prdata    = (paddr[2] == ppu_pkg::REG_PIXEL_MODE) ? {30'b0, mode_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ppu_pkg::MODE_RESET;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    ppu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_mode (mode_reg),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .queue_full (status.full),
        .push       (push),
        .push_group (push_group)
    );

    ppu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .pop        (pop),
        .head_group (head_group),
        .status     (status)
    );

    ppu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_group  (head_group),
        .status      (status),
        .pop         (pop),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_data  (pixel_data)
    );

endmodule

@@ rtl/core/ppu_checker.sv @@
module ppu_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 psel,
    input logic                 penable,
    input logic                 pwrite,
    input logic [2:0]           paddr,
    input logic [31:0]          pwdata,
    input logic [31:0]          prdata,
    input logic                 pready,
    input logic                 byte_valid,
    input logic                 byte_stall,
    input ppu_pkg::byte_beat_t  byte_data,
    input logic                 pixel_valid,
    input logic                 pixel_stall,
    input ppu_pkg::pixel_beat_t pixel_data
);

    // A stalled pixel beat holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_data))
    else $error("stalled pixel beat changed");

    // A stalled byte beat stays on the port unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(byte_data))
    else $error("stalled byte beat changed");

    // The register port never inserts wait states.
    assert property (@(posedge clk) pready)
    else $error("pready dropped");

    // A mode write reads back on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[2] == ppu_pkg::REG_PIXEL_MODE)
        |=> (paddr[2] != ppu_pkg::REG_PIXEL_MODE) || (prdata[1:0] == $past(pwdata[1:0])))
    else $error("pixel_mode readback mismatch");

    // Only the two mode bits of the register read back as non-zero.
    assert property (@(posedge clk) prdata[31:2] == 30'b0)
    else $error("unused register bits set");

endmodule

bind packed_pixel_unpacker ppu_checker u_ppu_checker (.*);
